// File: rtl/sdc_pkg.sv
// Shared types and fixed constants for the subset difference counter.
// Used by the top level and by its port checker; depends on nothing.

package sdc_pkg;

	// Width of the difference register and of the result fields.
	localparam int DIFF_W      = 13;
	localparam int OUT_COUNT_W = 32;
	localparam int OUT_USER_W  = 2;

	// Bit positions inside the result tuser word.
	localparam int USER_SAT_BIT = 0;
	localparam int USER_OVF_BIT = 1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SWEEP,
		S_DRAIN,
		S_LOOKUP,
		S_RESULT
	} state_t;

endpackage

// File: rtl/subset_difference_count.sv
// Subset difference counter: top level with the count table memory and control.
// Depends on sdc_pkg for the state type and the fixed field widths.
//
// Elements arrive one per input transfer; the transfer with tlast closes the array
// and yields one result transfer. The subset counts live in one memory of
// MAX_SUM/2+1 words with two read ports and one write port. An element e no larger
// than MAX_SUM/2 walks the table from MAX_SUM/2 down to e, one read-modify-write per
// cycle, and then drains its last write; a larger element only adds to the total.
// The closing element then passes through a lookup and a result state; the result
// state waits until the result register is free or taken, after which the table is
// rebuilt by a clearing pass over all MAX_SUM/2+1 entries during which no element is
// taken. The same clearing pass runs after reset. The difference register may be
// written at any time the block is idle; it is kept across arrays.

module subset_difference_count #(
	parameter int MAX_SUM     = 4096,
	parameter int ELEM_WIDTH  = 8,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Element stream.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [((ELEM_WIDTH+7)/8)*8-1:0]  s_tdata,   // [ELEM_WIDTH-1:0] element
	input  logic                             s_tlast,   // last element of the array
	// Result stream.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sdc_pkg::OUT_COUNT_W-1:0]  m_tdata,   // [31:0] subset_count
	output logic [sdc_pkg::OUT_USER_W-1:0]   m_tuser,   // [0] count_saturated, [1] sum_overflow
	// Difference register.
	input  logic                             diff_we,
	input  logic [sdc_pkg::DIFF_W-1:0]       diff_wdata
);

	localparam int HALF   = MAX_SUM / 2;
	localparam int ADDR_W = (HALF + 1 > 1) ? $clog2(HALF + 1) : 1;
	localparam int TOT_W  = $clog2(MAX_SUM + 2);
	localparam int SUM_W  = ((TOT_W > ELEM_WIDTH) ? TOT_W : ELEM_WIDTH) + 1;
	localparam int CMP_W  = ((SUM_W > sdc_pkg::DIFF_W) ? SUM_W : sdc_pkg::DIFF_W) + 1;

	sdc_pkg::state_t state_q, state_nx;

	logic [sdc_pkg::DIFF_W-1:0] diff_q;
	logic [TOT_W-1:0]           total_q;
	logic                       ovf_q;
	logic                       sat_q;
	logic [ADDR_W-1:0]          e_q;
	logic                       last_q;
	logic [ADDR_W-1:0]          s_q;
	logic [ADDR_W-1:0]          clr_q;
	logic                       hit_q;

	// Write-back stage of the sweep.
	logic                       vld_s1;
	logic [ADDR_W-1:0]          wa_s1;

	// Count table memory.
	logic [COUNT_WIDTH-1:0]     mem [0:HALF];
	logic [COUNT_WIDTH-1:0]     rd_a_q, rd_b_q;
	logic                       mem_re, mem_we;
	logic [ADDR_W-1:0]          mem_ra, mem_rb, mem_wa;
	logic [COUNT_WIDTH-1:0]     mem_wd;

	// Result register.
	logic                       out_valid_q;
	logic [sdc_pkg::OUT_COUNT_W-1:0] out_count_q;
	logic                       out_sat_q, out_ovf_q;

	logic                       in_xfer;
	logic                       load_out;
	logic [SUM_W-1:0]           elem_ext;
	logic                       e_fits;
	logic [SUM_W-1:0]           total_nx;
	logic [COUNT_WIDTH:0]       pair_sum;
	logic [COUNT_WIDTH-1:0]     sweep_wd;
	logic [CMP_W-1:0]           tot_c, diff_c, rem_c;
	logic                       split_ok;
	logic [ADDR_W-1:0]          lookup_idx;
	logic [63:0]                count_wide;

	assign in_xfer  = s_tvalid && s_tready;
	assign elem_ext = SUM_W'(s_tdata[ELEM_WIDTH-1:0]);
	assign e_fits   = elem_ext <= SUM_W'(HALF);
	assign total_nx = SUM_W'(total_q) + elem_ext;

	assign pair_sum = {1'b0, rd_a_q} + {1'b0, rd_b_q};
	assign sweep_wd = pair_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : pair_sum[COUNT_WIDTH-1:0];

	// The split exists only if diff fits under the total and leaves an even remainder.
	assign tot_c      = CMP_W'(total_q);
	assign diff_c     = CMP_W'(diff_q);
	assign rem_c      = tot_c - diff_c;
	assign split_ok   = !ovf_q && (diff_c <= tot_c) && !rem_c[0];
	assign lookup_idx = rem_c[ADDR_W:1];

	always_comb begin
		state_nx = state_q;
		case (state_q)
			sdc_pkg::S_CLEAR: begin
				if (clr_q == ADDR_W'(HALF)) state_nx = sdc_pkg::S_IDLE;
			end
			sdc_pkg::S_IDLE: begin
				if (in_xfer) begin
					if (e_fits) state_nx = sdc_pkg::S_SWEEP;
					else if (s_tlast) state_nx = sdc_pkg::S_LOOKUP;
				end
			end
			sdc_pkg::S_SWEEP: begin
				if (s_q == e_q) state_nx = sdc_pkg::S_DRAIN;
			end
			sdc_pkg::S_DRAIN: begin
				state_nx = last_q ? sdc_pkg::S_LOOKUP : sdc_pkg::S_IDLE;
			end
			sdc_pkg::S_LOOKUP: begin
				state_nx = sdc_pkg::S_RESULT;
			end
			sdc_pkg::S_RESULT: begin
				if (load_out) state_nx = sdc_pkg::S_CLEAR;
			end
			default: state_nx = sdc_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mem_re   = 1'b0;
		mem_ra   = s_q;
		mem_rb   = s_q - e_q;
		mem_we   = 1'b0;
		mem_wa   = wa_s1;
		mem_wd   = sweep_wd;
		load_out = 1'b0;
		case (state_q)
			sdc_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = (clr_q == '0) ? COUNT_WIDTH'(1) : '0;
			end
			sdc_pkg::S_IDLE: begin
				s_tready = 1'b1;
			end
			sdc_pkg::S_SWEEP: begin
				mem_re = 1'b1;
			end
			sdc_pkg::S_LOOKUP: begin
				mem_re = 1'b1;
				mem_ra = lookup_idx;
				mem_rb = lookup_idx;
			end
			sdc_pkg::S_RESULT: begin
				load_out = !out_valid_q || m_tready;
			end
			default: begin
			end
		endcase
		// The last sweep write lands in the drain cycle.
		if (vld_s1) mem_we = 1'b1;
	end

	// Reads and writes never meet on one entry: the sweep writes only above the
	// entries it still has to read.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) begin
			rd_a_q <= mem[mem_ra];
			rd_b_q <= mem[mem_rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sdc_pkg::S_CLEAR;
			diff_q      <= '0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			sat_q       <= 1'b0;
			clr_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= (state_q == sdc_pkg::S_SWEEP);
			if (diff_we) diff_q <= diff_wdata;
			if (state_q == sdc_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (in_xfer) begin
				if (total_nx > SUM_W'(MAX_SUM)) begin
					total_q <= TOT_W'(MAX_SUM + 1);
					ovf_q   <= 1'b1;
				end else begin
					total_q <= total_nx[TOT_W-1:0];
				end
			end
			if (vld_s1 && pair_sum[COUNT_WIDTH]) sat_q <= 1'b1;
			if (load_out) begin
				out_valid_q <= 1'b1;
				total_q     <= '0;
				ovf_q       <= 1'b0;
				sat_q       <= 1'b0;
				clr_q       <= '0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign count_wide = 64'(rd_a_q);

	always_ff @(posedge clk) begin
		wa_s1 <= s_q;
		if (in_xfer) begin
			e_q    <= elem_ext[ADDR_W-1:0];
			last_q <= s_tlast;
			s_q    <= ADDR_W'(HALF);
		end else if (state_q == sdc_pkg::S_SWEEP) begin
			s_q <= s_q - 1'b1;
		end
		if (state_q == sdc_pkg::S_LOOKUP) hit_q <= split_ok;
		if (load_out) begin
			out_count_q <= hit_q ? count_wide[sdc_pkg::OUT_COUNT_W-1:0] : '0;
			out_sat_q   <= sat_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_count_q;
	always_comb begin
		m_tuser = '0;
		m_tuser[sdc_pkg::USER_SAT_BIT] = out_sat_q;
		m_tuser[sdc_pkg::USER_OVF_BIT] = out_ovf_q;
	end

endmodule

// File: rtl/sdc_checker.sv
// Port-level checks for the subset difference counter, bound to its top level.
// Depends on sdc_pkg for the result field widths and tuser bit positions.

module sdc_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tlast,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [sdc_pkg::OUT_COUNT_W-1:0] m_tdata,
	input logic [sdc_pkg::OUT_USER_W-1:0]  m_tuser
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

	// Closing an array always makes the block busy in the next cycle.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("element taken right after the closing transfer");

	// A total overflow forces a zero count.
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[sdc_pkg::USER_OVF_BIT]) |-> (m_tdata == '0))
		else $error("nonzero count reported with total overflow");

	// A new result appears only while the table is being rebuilt.
	a_new_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !s_tready)
		else $error("result appeared while elements were being taken");

endmodule

bind subset_difference_count sdc_port_checks u_sdc_checker (.*);

// File: tb/sv/sdc_checker.sv
// Port checker for the subset difference counter: watches the element, result and
// difference-register ports, predicts each result and compares it field by field.
// Depends on sdc_pkg for the result field widths and the tuser bit positions.
`timescale 1ns / 1ps

module sdc_checker #(
	parameter int MAX_SUM     = 4096,
	parameter int ELEM_WIDTH  = 8,
	parameter int COUNT_WIDTH = 32,
	parameter int DATA_W      = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [DATA_W-1:0]                s_tdata,
	input  logic                             s_tlast,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [sdc_pkg::OUT_COUNT_W-1:0]  m_tdata,
	input  logic [sdc_pkg::OUT_USER_W-1:0]   m_tuser,
	input  logic                             diff_we,
	input  logic [sdc_pkg::DIFF_W-1:0]       diff_wdata,
	output int                               errors,
	output int                               pending,
	output int                               results_seen,
	output int                               saturated_seen,
	output int                               overflow_seen
);

	localparam int HALF = MAX_SUM / 2;

	typedef struct packed {
		logic [sdc_pkg::OUT_COUNT_W-1:0] count;
		logic                            sat;
		logic                            ovf;
	} split_result_t;

	// Subset counts per partial sum, plus the running state of the current array.
	bit [COUNT_WIDTH-1:0]     subset_counts [0:HALF];
	int unsigned              elem_total;
	bit                       sat_mark;
	bit                       ovf_mark;
	bit [sdc_pkg::DIFF_W-1:0] diff_reg;
	split_result_t            expected_splits [$];
	int                       err_cnt;
	int                       n_results;
	int                       n_sat;
	int                       n_ovf;

	function automatic void rearm_counts();
		for (int i = 0; i <= HALF; i++) subset_counts[i] = '0;
		subset_counts[0] = COUNT_WIDTH'(1);
		elem_total = 0;
		sat_mark = 1'b0;
		ovf_mark = 1'b0;
	endfunction

	// Walks the table from the top down so every element is used at most once.
	function automatic void absorb_element(input int unsigned e);
		bit [COUNT_WIDTH:0] sum;
		if (e <= HALF) begin
			for (int s = HALF; s >= int'(e); s--) begin
				sum = {1'b0, subset_counts[s]} + subset_counts[s - e];
				if (sum[COUNT_WIDTH]) begin
					subset_counts[s] = '1;
					sat_mark = 1'b1;
				end else begin
					subset_counts[s] = sum[COUNT_WIDTH-1:0];
				end
			end
		end
		elem_total += e;
		if (elem_total > MAX_SUM) begin
			elem_total = MAX_SUM + 1;
			ovf_mark = 1'b1;
		end
	endfunction

	function automatic split_result_t close_array();
		split_result_t r;
		int unsigned   idx;
		r.count = '0;
		if (!ovf_mark && diff_reg <= elem_total && ((elem_total - diff_reg) % 2) == 0) begin
			idx = (elem_total - diff_reg) / 2;
			if (idx <= HALF) r.count = sdc_pkg::OUT_COUNT_W'(subset_counts[idx]);
		end
		r.sat = sat_mark;
		r.ovf = ovf_mark;
		rearm_counts();
		return r;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		err_cnt++;
		if (err_cnt <= 25)
			$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		split_result_t want;
		split_result_t closed;
		if (!arst_n) begin
			rearm_counts();
			diff_reg = '0;
			expected_splits.delete();
		end else begin
			if (diff_we) diff_reg = diff_wdata;
			if (s_tvalid && s_tready) begin
				absorb_element(32'(s_tdata[ELEM_WIDTH-1:0]));
				if (s_tlast) begin
					closed = close_array();
					expected_splits = {expected_splits, closed};
				end
			end
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_splits.size() == 0) begin
					report("result transfer with nothing expected", m_tdata, 0);
				end else begin
					want = expected_splits.pop_front();
					if (m_tdata !== want.count) report("subset_count", m_tdata, want.count);
					if (m_tuser[sdc_pkg::USER_SAT_BIT] !== want.sat)
						report("count_saturated", m_tuser[sdc_pkg::USER_SAT_BIT], want.sat);
					if (m_tuser[sdc_pkg::USER_OVF_BIT] !== want.ovf)
						report("sum_overflow", m_tuser[sdc_pkg::USER_OVF_BIT], want.ovf);
					n_sat += want.sat;
					n_ovf += want.ovf;
				end
			end
		end
		// Published with nonblocking assignments so the stimulus sees stable values.
		errors <= err_cnt;
		pending <= expected_splits.size();
		results_seen <= n_results;
		saturated_seen <= n_sat;
		overflow_seen <= n_ovf;
	end

endmodule

// File: tb/sv/testbench.sv
// Top of the subset difference counter testbench: clock, reset, element stimulus,
// result back-pressure, difference register writes and the final verdict.
// Depends on sdc_pkg, subset_difference_count and sdc_checker.
`timescale 1ns / 1ps

module testbench;

	localparam int MAX_SUM      = 4096;
	localparam int ELEM_WIDTH   = 8;
	localparam int COUNT_WIDTH  = 32;
	localparam int DATA_W       = ((ELEM_WIDTH + 7) / 8) * 8;
	localparam int DIFF_MAX     = (1 << sdc_pkg::DIFF_W) - 1;
	// Covers the clearing pass over all MAX_SUM/2+1 table entries plus some margin.
	localparam int CLEAR_WAIT   = MAX_SUM / 2 + 65;
	localparam int RAND_ITEMS   = 290;
	localparam int LIMIT_CYCLES = 20000000;

	typedef enum int {RX_FULL, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;
	typedef enum int {ARR_MIXED, ARR_SMALL, ARR_SATURATE, ARR_OVERFLOW} array_kind_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [DATA_W-1:0]                s_tdata;     // [ELEM_WIDTH-1:0] element
	logic                             s_tlast;     // last element of the array
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [sdc_pkg::OUT_COUNT_W-1:0]  m_tdata;     // [31:0] subset_count
	logic [sdc_pkg::OUT_USER_W-1:0]   m_tuser;     // [0] count_saturated, [1] sum_overflow
	logic                             diff_we;
	logic [sdc_pkg::DIFF_W-1:0]       diff_wdata;

	int errors;
	int pending;
	int results_seen;
	int saturated_seen;
	int overflow_seen;

	bit [ELEM_WIDTH-1:0] array_q [$];
	int                  burst_left;
	int                  elems_sent;
	int                  arrays_sent;
	int                  diff_writes;
	int                  cycle_cnt = 0;
	int                  ready_left = 0;
	rx_mode_t            ready_mode = RX_FULL;

	subset_difference_count #(
		.MAX_SUM     (MAX_SUM),
		.ELEM_WIDTH  (ELEM_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.diff_we    (diff_we),
		.diff_wdata (diff_wdata)
	);

	sdc_checker #(
		.MAX_SUM     (MAX_SUM),
		.ELEM_WIDTH  (ELEM_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH),
		.DATA_W      (DATA_W)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.diff_we        (diff_we),
		.diff_wdata     (diff_wdata),
		.errors         (errors),
		.pending        (pending),
		.results_seen   (results_seen),
		.saturated_seen (saturated_seen),
		.overflow_seen  (overflow_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
			$display("Some tests failed");
			$finish;
		end
	end

	// The result side switches at random between its own stall patterns.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= rx_mode_t'($urandom_range(0, 3));
			ready_left <= $urandom_range(16, 400);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			RX_FULL: begin
				m_tready <= 1'b1;
			end
			RX_COIN: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			RX_PERIODIC: begin
				m_tready <= (ready_left[1:0] == 2'd0);
			end
			default: begin
				m_tready <= ($urandom_range(0, 15) == 0);
			end
		endcase
	end

	task automatic send_elem(input bit [ELEM_WIDTH-1:0] e, input bit is_last);
		int r;
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= DATA_W'(e);
		s_tlast <= is_last;
		do @(posedge clk); while (!s_tready);
		elems_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			r = $urandom_range(0, 15);
			if (r < 6) gap = 0;
			else if (r < 13) gap = $urandom_range(1, 20);
			else if (r < 15) gap = $urandom_range(21, 400);
			else gap = $urandom_range(401, 2500);
			// Valid is only lowered when time passes before the next transfer.
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 6);
		end
	endtask

	// Waits for every result and the clearing pass before touching the register.
	task automatic write_diff(input bit [sdc_pkg::DIFF_W-1:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (CLEAR_WAIT) @(posedge clk);
		diff_we <= 1'b1;
		diff_wdata <= v;
		@(posedge clk);
		diff_we <= 1'b0;
		diff_writes++;
	endtask

	// A negative difference keeps the current register value.
	task automatic send_array(input int d);
		if (d >= 0) write_diff(d[sdc_pkg::DIFF_W-1:0]);
		for (int i = 0; i < array_q.size(); i++)
			send_elem(array_q[i], i == array_q.size() - 1);
		arrays_sent++;
	endtask

	task automatic directed(input int d, input int n, input bit [63:0] elems);
		array_q.delete();
		for (int i = 0; i < n; i++) array_q = {array_q, elems[8*i +: ELEM_WIDTH]};
		send_array(d);
	endtask

	initial begin
		array_kind_t kind;
		int          rand_items;
		int          total;
		int          len;
		int          d;
		int          r;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		diff_we = 1'b0;
		diff_wdata = '0;
		arst_n = 1'b0;
		burst_left = $urandom_range(1, 6);
		elems_sent = 0;
		arrays_sent = 0;
		diff_writes = 0;
		rand_items = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Odd total, zero doubling, simple splits, difference above the total,
		// the widest difference, a zero-sum split and a trailing zero element.
		directed(0, 1, 64'hFF);
		directed(-1, 3, 64'h000000);
		directed(-1, 3, 64'h030201);
		directed(2, 4, 64'h04020101);
		directed(MAX_SUM, 1, 64'hFF);
		directed(DIFF_MAX, 2, 64'hFFFF);
		directed(255, 1, 64'hFF);
		directed(1, 3, 64'h007F80);
		directed(-1, 2, 64'h0403);

		while (rand_items < RAND_ITEMS) begin
			// The first two random arrays force count saturation and total overflow.
			if (arrays_sent == 9) begin
				kind = ARR_SATURATE;
			end else if (arrays_sent == 10) begin
				kind = ARR_OVERFLOW;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 78) kind = ARR_MIXED;
				else if (r < 94) kind = ARR_SMALL;
				else if (r < 97) kind = ARR_SATURATE;
				else kind = ARR_OVERFLOW;
			end
			array_q.delete();
			case (kind)
				ARR_MIXED: begin
					len = $urandom_range(1, 8);
					for (int i = 0; i < len; i++) begin
						r = $urandom_range(0, 3);
						array_q = {array_q, ELEM_WIDTH'(r == 0 ? $urandom_range(0, 15) :
							$urandom_range(0, (1 << ELEM_WIDTH) - 1))};
					end
				end
				ARR_SMALL: begin
					len = $urandom_range(9, 20);
					for (int i = 0; i < len; i++)
						array_q = {array_q, ELEM_WIDTH'($urandom_range(0, 3))};
				end
				ARR_SATURATE: begin
					// More than COUNT_WIDTH zeros push the count at sum zero past its maximum.
					for (int i = 0; i <= COUNT_WIDTH; i++) array_q = {array_q, ELEM_WIDTH'(0)};
					len = $urandom_range(0, 3);
					for (int i = 0; i < len; i++)
						array_q = {array_q, ELEM_WIDTH'($urandom_range(0, 3))};
				end
				default: begin
					len = $urandom_range(18, 20);
					for (int i = 0; i < len; i++)
						array_q = {array_q, ELEM_WIDTH'($urandom_range(240, 255))};
				end
			endcase
			total = 0;
			foreach (array_q[i]) total += array_q[i];

			d = -1;
			if (kind == ARR_SATURATE || kind == ARR_OVERFLOW || $urandom_range(0, 9) < 4) begin
				r = $urandom_range(0, 9);
				if (r < 6 && total <= MAX_SUM) begin
					d = total - 2 * $urandom_range(0, total / 2);
				end else if (r < 8) begin
					d = $urandom_range(0, DIFF_MAX);
				end else begin
					case ($urandom_range(0, 4))
						0: d = 0;
						1: d = MAX_SUM;
						2: d = DIFF_MAX;
						3: d = total;
						default: d = total + 1;
					endcase
				end
			end
			send_array(d);
			rand_items += array_q.size();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (CLEAR_WAIT) @(posedge clk);

		$display("Sent %0d elements in %0d arrays with %0d difference register writes.",
			elems_sent, arrays_sent, diff_writes);
		$display("Checked %0d results, %0d with saturated counts, %0d with sum overflow.",
			results_seen, saturated_seen, overflow_seen);
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
